// File: sv/sctd_pkg.sv
// Shared widths, types and constants for the seconds-to-calendar-date converter.
package sctd_pkg;

  // Field widths
  localparam int EpochW = 32;
  localparam int YearW  = 12;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int WdayW  = 3;

  // Internal widths
  localparam int DaysW = 16;   // days since epoch, up to 49710
  localparam int HmsW  = 17;   // seconds within a day
  localparam int MpW   = 4;    // month counted from March, 0..11
  localparam int DoyW  = 9;    // day of March-based year, 0..365

  // Seconds to days: secs / 86400 = (secs >> 7) / 675, reciprocal floor(2^32 / 675)
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [22:0] DayRecip   = 23'd6362914;
  localparam logic [15:0] MaxDays    = 16'd49710;

  // Day-of-time splits
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [13:0] HourRecip   = 14'd9321;   // ceil(2^21 / 225)
  localparam logic [10:0] MinRecip    = 11'd1093;   // ceil(2^14 / 15)

  // Calendar counted from 0000-03-01
  localparam logic [19:0] ShiftTo0000  = 20'd719468;
  localparam logic [17:0] DaysPer400Y  = 18'd146097;
  localparam logic [19:0] Era4Start    = 20'd584388;   // 4 * 146097
  localparam logic [19:0] Era5Start    = 20'd730485;   // 5 * 146097
  localparam logic [15:0] Recip1460    = 16'd45965;    // ceil(2^24 / 365), applied to doe >> 2
  localparam logic [17:0] Recip365     = 18'd183860;   // ceil(2^26 / 365)
  localparam logic [11:0] MpRecip      = 12'd3427;     // ceil(2^19 / 153)
  localparam logic [11:0] BaseYear     = 12'd1600;

  // Payload between the day divider and the calendar pipeline
  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [HmsW-1:0]  hms;
  } day_split_t;

  // First day of each March-based month: (153 * mp + 2) / 5
  function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
    logic [DoyW-1:0] ofs;
    unique case (mp)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// File: sv/sctd_if.sv
// Request and result channel interfaces of the converter.
interface sctd_in_if;
  import sctd_pkg::*;

  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface sctd_out_if;
  import sctd_pkg::*;

  logic             valid;
  logic             ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day_of_month;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second;
  logic [WdayW-1:0]  weekday;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  output ready);
endinterface

// File: sv/sctd_day_div.sv
// Three-stage divider: seconds since epoch into whole days and seconds of day.
module sctd_day_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  sctd_in_if.sink             req_i,
  output logic                day_vld_o,
  input  logic                day_rdy_i,
  output sctd_pkg::day_split_t day_o
);
  import sctd_pkg::*;

  localparam int NumStg = 3;
  localparam logic [17:0] TwoDays = 18'(2 * 86400);

  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   adv;

  logic [47:0]       s1_prod;
  logic [DaysW-1:0]  s1_days_d, s1_days_q;
  logic [EpochW-1:0] s1_secs_q;
  logic [32:0]       s2_sub;
  logic [17:0]       s2_rem_d, s2_rem_q;
  logic [DaysW-1:0]  s2_days_q;
  logic [DaysW-1:0]  days_d, days_q;
  logic [HmsW-1:0]   hms_d, hms_q;

  // Stage advance: a stage loads when empty or when its contents move on
  always_comb begin
    adv[NumStg] = day_rdy_i;
    for (int i = NumStg - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= req_i.valid;
      for (int i = 1; i < NumStg; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 1: day estimate by reciprocal, low by at most one
  assign s1_prod   = 48'(req_i.epoch_seconds[31:7]) * 48'(DayRecip);
  assign s1_days_d = s1_prod[47:32];

  // Stage 2: remainder against the estimate, below two days
  assign s2_sub   = {1'b0, s1_secs_q} - 33'(s1_days_q) * 33'(SecsPerDay);
  assign s2_rem_d = s2_sub[17:0];

  // Stage 3: one correction step
  always_comb begin
    if (s2_rem_q >= 18'(SecsPerDay)) begin
      days_d = s2_days_q + 16'd1;
      hms_d  = 17'(s2_rem_q - 18'(SecsPerDay));
    end else begin
      days_d = s2_days_q;
      hms_d  = s2_rem_q[HmsW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_secs_q <= req_i.epoch_seconds;
      s1_days_q <= s1_days_d;
    end
    if (adv[1]) begin
      s2_days_q <= s1_days_q;
      s2_rem_q  <= s2_rem_d;
    end
    if (adv[2]) begin
      days_q <= days_d;
      hms_q  <= hms_d;
    end
  end

  assign req_i.ready = adv[0];
  assign day_vld_o   = vld_q[NumStg-1];
  assign day_o.days  = days_q;
  assign day_o.hms   = hms_q;

  // Estimate never falls more than one day short
  assert property (@(posedge clk_i) disable iff (!rst_ni) vld_q[1] |-> s2_rem_q < TwoDays)
    else $error("day estimate off by more than one");

  // Corrected result is a proper split
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   vld_q[2] |-> (hms_q < SecsPerDay) && (days_q <= MaxDays))
    else $error("day split out of range");

  // A held result does not change under stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   vld_q[2] && !day_rdy_i |=> vld_q[2] && $stable(days_q) && $stable(hms_q))
    else $error("stalled day split changed");

endmodule

// File: sv/sctd_civil.sv
// Six-stage calendar pipeline: day count and seconds of day into date, time and weekday.
module sctd_civil (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 day_vld_i,
  output logic                 day_rdy_o,
  input  sctd_pkg::day_split_t day_i,
  sctd_out_if.source           res_o
);
  import sctd_pkg::*;

  localparam int NumStg = 6;

  // Remainder mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [WdayW-1:0] mod7(input logic [DaysW-1:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) return 3'(s2 - 4'd7);
    return s2[2:0];
  endfunction

  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   adv;

  // Stage A
  logic [19:0]       a_z;
  logic              a_era5_d, a_era5_q;
  logic [17:0]       a_doe_d, a_doe_q;
  logic [WdayW-1:0]  a_wday_d, a_wday_q;
  logic [26:0]       a_hprod;
  logic [HourW-1:0]  a_hour_d, a_hour_q;
  logic [HmsW-1:0]   a_hms_q;
  // Stage B
  logic [31:0]       b_prod;
  logic [6:0]        b_q1460;
  logic [2:0]        b_q36524;
  logic              b_last;
  logic [17:0]       b_t_d, b_t_q;
  logic [16:0]       b_hsecs;
  logic [11:0]       b_remh_d, b_remh_q;
  logic [17:0]       b_doe_q;
  logic              b_era5_q;
  logic [WdayW-1:0]  b_wday_q;
  logic [HourW-1:0]  b_hour_q;
  // Stage C
  logic [35:0]       c_prod;
  logic [8:0]        c_yoe_d, c_yoe_q;
  logic [20:0]       c_mprod;
  logic [MinW-1:0]   c_min_d, c_min_q;
  logic [11:0]       c_remh_q;
  logic [17:0]       c_doe_q;
  logic              c_era5_q;
  logic [WdayW-1:0]  c_wday_q;
  logic [HourW-1:0]  c_hour_q;
  // Stage D
  logic [1:0]        d_cent;
  logic [17:0]       d_ybase;
  logic [17:0]       d_doy_full;
  logic [DoyW-1:0]   d_doy_d, d_doy_q;
  logic [11:0]       d_sfull;
  logic [SecW-1:0]   d_sec_d, d_sec_q;
  logic [8:0]        d_yoe_q;
  logic              d_era5_q;
  logic [WdayW-1:0]  d_wday_q;
  logic [HourW-1:0]  d_hour_q;
  logic [MinW-1:0]   d_min_q;
  // Stage E
  logic [10:0]       e_n;
  logic [22:0]       e_prod;
  logic [MpW-1:0]    e_mp_d, e_mp_q;
  logic [DoyW-1:0]   e_doy_q;
  logic [8:0]        e_yoe_q;
  logic              e_era5_q;
  logic [WdayW-1:0]  e_wday_q;
  logic [HourW-1:0]  e_hour_q;
  logic [MinW-1:0]   e_min_q;
  logic [SecW-1:0]   e_sec_q;
  // Stage F (result register)
  logic [DoyW-1:0]   f_dfull;
  logic [MonthW-1:0] f_mon_d, f_mon_q;
  logic [DayW-1:0]   f_day_d, f_day_q;
  logic [YearW-1:0]  f_year_d, f_year_q;
  logic [WdayW-1:0]  f_wday_q;
  logic [HourW-1:0]  f_hour_q;
  logic [MinW-1:0]   f_min_q;
  logic [SecW-1:0]   f_sec_q;

  // Stage advance chain
  always_comb begin
    adv[NumStg] = res_o.ready;
    for (int i = NumStg - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= day_vld_i;
      for (int i = 1; i < NumStg; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage A: shift to 0000-03-01, pick the 400-year era, weekday, hour
  assign a_z      = 20'(day_i.days) + ShiftTo0000;
  assign a_era5_d = (a_z >= Era5Start);
  assign a_doe_d  = 18'(a_z - (a_era5_d ? Era5Start : Era4Start));
  assign a_wday_d = mod7(day_i.days + 16'd4);
  assign a_hprod  = 27'(day_i.hms[16:4]) * 27'(HourRecip);
  assign a_hour_d = a_hprod[25:21];

  // Stage B: leap-day corrections of the day of era; seconds within the hour
  assign b_prod   = 32'(a_doe_q[17:2]) * 32'(Recip1460);
  assign b_q1460  = b_prod[30:24];
  assign b_q36524 = 3'(a_doe_q >= 18'd36524) + 3'(a_doe_q >= 18'd73048) +
                    3'(a_doe_q >= 18'd109572) + 3'(a_doe_q >= 18'd146096);
  assign b_last   = (a_doe_q == 18'd146096);
  assign b_t_d    = a_doe_q - 18'(b_q1460) + 18'(b_q36524) - 18'(b_last);
  assign b_hsecs  = 17'(a_hour_q) * 17'(SecsPerHour);
  assign b_remh_d = 12'(a_hms_q - b_hsecs);

  // Stage C: year of era; minute
  assign c_prod  = 36'(b_t_q) * 36'(Recip365);
  assign c_yoe_d = c_prod[34:26];
  assign c_mprod = 21'(b_remh_q[11:2]) * 21'(MinRecip);
  assign c_min_d = c_mprod[19:14];

  // Stage D: day of March-based year; second
  assign d_cent     = 2'(c_yoe_q >= 9'd100) + 2'(c_yoe_q >= 9'd200) + 2'(c_yoe_q >= 9'd300);
  assign d_ybase    = 18'(c_yoe_q) * 18'd365 + 18'(c_yoe_q[8:2]) - 18'(d_cent);
  assign d_doy_full = c_doe_q - d_ybase;
  assign d_doy_d    = d_doy_full[DoyW-1:0];
  assign d_sfull    = c_remh_q - 12'(c_min_q) * 12'd60;
  assign d_sec_d    = d_sfull[SecW-1:0];

  // Stage E: March-based month
  assign e_n    = 11'(d_doy_q) * 11'd5 + 11'd2;
  assign e_prod = 23'(e_n) * 23'(MpRecip);
  assign e_mp_d = e_prod[22:19];

  // Stage F: day of month, calendar month, year
  assign f_dfull  = e_doy_q - month_start(e_mp_q) + 9'd1;
  assign f_day_d  = f_dfull[DayW-1:0];
  assign f_mon_d  = (e_mp_q < 4'd10) ? e_mp_q + 4'd3 : e_mp_q - 4'd9;
  assign f_year_d = BaseYear + (e_era5_q ? 12'd400 : 12'd0) + 12'(e_yoe_q) +
                    12'(f_mon_d <= 4'd2);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a_era5_q <= a_era5_d;
      a_doe_q  <= a_doe_d;
      a_wday_q <= a_wday_d;
      a_hour_q <= a_hour_d;
      a_hms_q  <= day_i.hms;
    end
    if (adv[1]) begin
      b_t_q    <= b_t_d;
      b_remh_q <= b_remh_d;
      b_doe_q  <= a_doe_q;
      b_era5_q <= a_era5_q;
      b_wday_q <= a_wday_q;
      b_hour_q <= a_hour_q;
    end
    if (adv[2]) begin
      c_yoe_q  <= c_yoe_d;
      c_min_q  <= c_min_d;
      c_remh_q <= b_remh_q;
      c_doe_q  <= b_doe_q;
      c_era5_q <= b_era5_q;
      c_wday_q <= b_wday_q;
      c_hour_q <= b_hour_q;
    end
    if (adv[3]) begin
      d_doy_q  <= d_doy_d;
      d_sec_q  <= d_sec_d;
      d_yoe_q  <= c_yoe_q;
      d_era5_q <= c_era5_q;
      d_wday_q <= c_wday_q;
      d_hour_q <= c_hour_q;
      d_min_q  <= c_min_q;
    end
    if (adv[4]) begin
      e_mp_q   <= e_mp_d;
      e_doy_q  <= d_doy_q;
      e_yoe_q  <= d_yoe_q;
      e_era5_q <= d_era5_q;
      e_wday_q <= d_wday_q;
      e_hour_q <= d_hour_q;
      e_min_q  <= d_min_q;
      e_sec_q  <= d_sec_q;
    end
    if (adv[5]) begin
      f_year_q <= f_year_d;
      f_mon_q  <= f_mon_d;
      f_day_q  <= f_day_d;
      f_wday_q <= e_wday_q;
      f_hour_q <= e_hour_q;
      f_min_q  <= e_min_q;
      f_sec_q  <= e_sec_q;
    end
  end

  assign day_rdy_o          = adv[0];
  assign res_o.valid        = vld_q[NumStg-1];
  assign res_o.year         = f_year_q;
  assign res_o.month        = f_mon_q;
  assign res_o.day_of_month = f_day_q;
  assign res_o.hour         = f_hour_q;
  assign res_o.minute       = f_min_q;
  assign res_o.second       = f_sec_q;
  assign res_o.weekday      = f_wday_q;

  // Era selection leaves a day of era inside one 400-year cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) vld_q[0] |-> a_doe_q < DaysPer400Y)
    else $error("day of era out of range");

  // Year of era and minute from the reciprocal steps stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   vld_q[2] |-> (c_yoe_q <= 9'd399) && (c_min_q < 6'd60))
    else $error("year of era or minute out of range");

  // March-based month and day of year agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   vld_q[4] |-> (e_mp_q <= 4'd11) && (e_doy_q >= month_start(e_mp_q)))
    else $error("month index out of range");

  // A result waiting at the output holds its date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_o.valid && !res_o.ready |=> $stable(f_year_q) && $stable(f_day_q))
    else $error("stalled result changed");

endmodule

// File: sv/seconds_to_calendar_date.sv
// Top level: epoch seconds to Gregorian date, time of day and weekday.
//
//   channel  port   dir  fields
//   -------  -----  ---  --------------------------------------------------------
//   request  req_i  in   epoch_seconds[31:0]
//   result   res_o  out  year, month, day_of_month, hour, minute, second, weekday
//
// One request per cycle sustained while res_o accepts results; a result passes
// through 9 register stages: 3 of day division, 6 of calendar math.
// The depth comes from the chain of constant divisions, each done as a reciprocal multiply.
// Reset clears only the stage valid bits; there is no clearing pass.
// A stall at res_o holds full stages up to the first empty one, which keeps filling;
// no request is lost or repeated and ready drops only when the pipe is full.
module seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  sctd_in_if.sink     req_i,
  sctd_out_if.source  res_o
);
  import sctd_pkg::*;

  logic       day_vld;
  logic       day_rdy;
  day_split_t day_split;

  // Seconds into days and seconds of day
  sctd_day_div u_day_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .day_vld_o (day_vld),
    .day_rdy_i (day_rdy),
    .day_o     (day_split)
  );

  // Days into date and weekday, seconds of day into time
  sctd_civil u_civil (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .day_vld_i (day_vld),
    .day_rdy_o (day_rdy),
    .day_i     (day_split),
    .res_o     (res_o)
  );

endmodule
